// ----- rtl/core/ffpa_pkg.sv -----
package ffpa_pkg;

  // Default geometry of the managed page.
  localparam int PageBytesDef    = 4096;
  localparam int GranuleBytesDef = 8;
  localparam int GranuleCountDef = 512;

  // Action codes carried by action_i.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_SIZE = 2'd1;
  localparam logic [1:0] STAT_NO_FIT   = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE = 2'd3;

  // Per-field write enables of the chunk table.
  typedef struct packed {
    logic len;
    logic used;
    logic start;
    logic prev;
  } mem_we_t;

endpackage

// ----- rtl/core/ffpa_alu.sv -----
module ffpa_alu import ffpa_pkg::*; #(
  parameter int W = 10
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W:0]   y_o
);

  // One adder serves both add and subtract; for subtract the top bit is the borrow.
  assign y_o = {1'b0, a_i} + ({1'b0, b_i} ^ {(W+1){sub_i}}) + (W+1)'(sub_i);

endmodule

// ----- rtl/core/ffpa_mem.sv -----
module ffpa_mem import ffpa_pkg::*; #(
  parameter int GRANULE_COUNT = GranuleCountDef
) (
  input  logic                               clk_i,
  input  logic [$clog2(GRANULE_COUNT)-1:0]   addr_i,
  input  mem_we_t                            we_i,
  input  logic [$clog2(GRANULE_COUNT+1)-1:0] w_len_i,
  input  logic                               w_used_i,
  input  logic                               w_start_i,
  input  logic [$clog2(GRANULE_COUNT+1)-1:0] w_prev_i,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] r_len_o,
  output logic                               r_used_o,
  output logic                               r_start_o,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] r_prev_o
);

  localparam int LW = $clog2(GRANULE_COUNT + 1);

  logic [LW-1:0] len_mem   [GRANULE_COUNT];
  logic          used_mem  [GRANULE_COUNT];
  logic          start_mem [GRANULE_COUNT];
  logic [LW-1:0] prev_mem  [GRANULE_COUNT];

  // Chunk table fields share one address; each field has its own write enable.
  always_ff @(posedge clk_i) begin
    if (we_i.len) begin
      len_mem[addr_i] <= w_len_i;
    end
    if (we_i.used) begin
      used_mem[addr_i] <= w_used_i;
    end
    if (we_i.start) begin
      start_mem[addr_i] <= w_start_i;
    end
    if (we_i.prev) begin
      prev_mem[addr_i] <= w_prev_i;
    end
    r_len_o   <= len_mem[addr_i];
    r_used_o  <= used_mem[addr_i];
    r_start_o <= start_mem[addr_i];
    r_prev_o  <= prev_mem[addr_i];
  end

endmodule

// ----- rtl/core/ffpa_ctrl.sv -----
module ffpa_ctrl import ffpa_pkg::*; #(
  parameter int PAGE_BYTES    = PageBytesDef,
  parameter int GRANULE_BYTES = GranuleBytesDef,
  parameter int GRANULE_COUNT = GranuleCountDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action_i,
  input  logic [12:0]                        request_bytes_i,
  input  logic [11:0]                        free_offset_i,
  output logic                               done_o,
  output logic [1:0]                         status_o,
  output logic [11:0]                        chunk_offset_o,
  output logic [$clog2(GRANULE_COUNT)-1:0]   addr_o,
  output mem_we_t                            we_o,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] w_len_o,
  output logic                               w_used_o,
  output logic                               w_start_o,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] w_prev_o,
  input  logic [$clog2(GRANULE_COUNT+1)-1:0] r_len_i,
  input  logic                               r_used_i,
  input  logic                               r_start_i,
  input  logic [$clog2(GRANULE_COUNT+1)-1:0] r_prev_i,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] alu_a_o,
  output logic [$clog2(GRANULE_COUNT+1)-1:0] alu_b_o,
  output logic                               alu_sub_o,
  input  logic [$clog2(GRANULE_COUNT+1):0]   alu_y_i
);

  localparam int IW = $clog2(GRANULE_COUNT);
  localparam int LW = $clog2(GRANULE_COUNT + 1);
  localparam int SH = $clog2(GRANULE_BYTES);
  localparam logic [LW-1:0] GC_L   = LW'(GRANULE_COUNT);
  localparam logic [LW:0]   GC_Y   = (LW+1)'(GRANULE_COUNT);
  localparam logic [IW-1:0] LAST   = IW'(GRANULE_COUNT - 1);
  localparam logic [12:0]   BMASK  = 13'(GRANULE_BYTES - 1);
  localparam logic [11:0]   OMASK  = 12'(GRANULE_BYTES - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE,
    S_A_RD, S_A_CHK, S_A_NEXT, S_A_SPLIT1, S_A_SPLIT2, S_A_SPLIT3, S_A_EXACT,
    S_F_RD, S_F_CHK, S_F_RRD, S_F_RCHK, S_F_RLNK, S_F_CLR,
    S_F_LRD, S_F_LCHK, S_F_LST, S_F_LLNK
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [LW-1:0] i_q, i_d, want_q, want_d, len_q, len_d, prev_q, prev_d;
  logic [LW-1:0] rest_q, rest_d, diff_q, diff_d, tmp_q, tmp_d, idx_q, idx_d;
  logic          done_q, done_d;
  logic [1:0]    status_q, status_d;
  logic [11:0]   off_q, off_d;
  logic          bad_size, bad_free;
  logic [31:0]   off_wide;

  // Request checks made at the moment an item is taken.
  assign bad_size = (request_bytes_i == 13'd0) || ((request_bytes_i & BMASK) != 13'd0) ||
                    (32'(request_bytes_i) > 32'(PAGE_BYTES));
  assign bad_free = ((free_offset_i & OMASK) != 12'd0) ||
                    (32'(free_offset_i >> SH) >= 32'(GRANULE_COUNT));
  assign off_wide = 32'(i_q) << SH;

  // Sequencer: one table access and one shared adder operation per cycle.
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    i_d       = i_q;
    want_d    = want_q;
    len_d     = len_q;
    prev_d    = prev_q;
    rest_d    = rest_q;
    diff_d    = diff_q;
    tmp_d     = tmp_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    status_d  = status_q;
    off_d     = off_q;
    addr_o    = '0;
    we_o      = '0;
    w_len_o   = len_q;
    w_used_o  = 1'b0;
    w_start_o = 1'b0;
    w_prev_o  = i_q;
    alu_a_o   = i_q;
    alu_b_o   = len_q;
    alu_sub_o = 1'b0;
    case (state_q)
      S_CLR: begin
        addr_o    = clr_q;
        we_o      = '{len: 1'b1, used: 1'b1, start: 1'b1, prev: 1'b1};
        w_len_o   = (clr_q == '0) ? GC_L : '0;
        w_start_o = (clr_q == '0);
        w_prev_o  = (clr_q == '0) ? GC_L : '0;
        if (clr_q == LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (action_i == ACT_ALLOC) begin
            if (bad_size) begin
              done_d   = 1'b1;
              status_d = STAT_BAD_SIZE;
              off_d    = '0;
            end else begin
              want_d  = LW'(request_bytes_i >> SH);
              i_d     = '0;
              state_d = S_A_RD;
            end
          end else begin
            if (bad_free) begin
              done_d   = 1'b1;
              status_d = STAT_BAD_FREE;
              off_d    = '0;
            end else begin
              idx_d   = LW'(free_offset_i >> SH);
              state_d = S_F_RD;
            end
          end
        end
      end
      S_A_RD: begin
        addr_o  = i_q[IW-1:0];
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        alu_a_o   = r_len_i;
        alu_b_o   = want_q;
        alu_sub_o = 1'b1;
        len_d     = r_len_i;
        diff_d    = alu_y_i[LW-1:0];
        if (r_len_i == '0) begin
          done_d   = 1'b1;
          status_d = STAT_NO_FIT;
          off_d    = '0;
          state_d  = S_IDLE;
        end else if (!r_used_i && !alu_y_i[LW]) begin
          state_d = (alu_y_i[LW-1:0] == '0) ? S_A_EXACT : S_A_SPLIT1;
        end else begin
          state_d = S_A_NEXT;
        end
      end
      S_A_NEXT: begin
        if (alu_y_i >= GC_Y) begin
          done_d   = 1'b1;
          status_d = STAT_NO_FIT;
          off_d    = '0;
          state_d  = S_IDLE;
        end else begin
          i_d     = alu_y_i[LW-1:0];
          state_d = S_A_RD;
        end
      end
      S_A_SPLIT1: begin
        alu_b_o = want_q;
        rest_d  = alu_y_i[LW-1:0];
        state_d = S_A_SPLIT2;
      end
      S_A_SPLIT2: begin
        // The remainder becomes a new free chunk behind the allocated part.
        addr_o    = rest_q[IW-1:0];
        we_o      = '{len: 1'b1, used: 1'b1, start: 1'b1, prev: 1'b1};
        w_len_o   = diff_q;
        w_start_o = 1'b1;
        w_prev_o  = i_q;
        alu_a_o   = rest_q;
        alu_b_o   = diff_q;
        tmp_d     = alu_y_i[LW-1:0];
        state_d   = (alu_y_i < GC_Y) ? S_A_SPLIT3 : S_A_EXACT;
      end
      S_A_SPLIT3: begin
        addr_o   = tmp_q[IW-1:0];
        we_o     = '{len: 1'b0, used: 1'b0, start: 1'b0, prev: 1'b1};
        w_prev_o = rest_q;
        state_d  = S_A_EXACT;
      end
      S_A_EXACT: begin
        addr_o   = i_q[IW-1:0];
        we_o     = '{len: 1'b1, used: 1'b1, start: 1'b0, prev: 1'b0};
        w_len_o  = want_q;
        w_used_o = 1'b1;
        done_d   = 1'b1;
        status_d = STAT_OK;
        off_d    = off_wide[11:0];
        state_d  = S_IDLE;
      end
      S_F_RD: begin
        addr_o  = idx_q[IW-1:0];
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        alu_a_o = idx_q;
        alu_b_o = r_len_i;
        if (!r_start_i || !r_used_i) begin
          done_d   = 1'b1;
          status_d = STAT_BAD_FREE;
          off_d    = '0;
          state_d  = S_IDLE;
        end else begin
          len_d   = r_len_i;
          prev_d  = r_prev_i;
          rest_d  = alu_y_i[LW-1:0];
          state_d = (alu_y_i < GC_Y) ? S_F_RRD : S_F_CLR;
        end
      end
      S_F_RRD: begin
        addr_o  = rest_q[IW-1:0];
        state_d = S_F_RCHK;
      end
      S_F_RCHK: begin
        // Absorb a free right neighbor.
        alu_a_o = len_q;
        alu_b_o = r_len_i;
        if (!r_used_i) begin
          len_d   = alu_y_i[LW-1:0];
          addr_o  = rest_q[IW-1:0];
          we_o    = '{len: 1'b0, used: 1'b0, start: 1'b1, prev: 1'b0};
          state_d = S_F_RLNK;
        end else begin
          state_d = S_F_CLR;
        end
      end
      S_F_RLNK: begin
        alu_a_o  = idx_q;
        addr_o   = alu_y_i[IW-1:0];
        w_prev_o = idx_q;
        if (alu_y_i < GC_Y) begin
          we_o = '{len: 1'b0, used: 1'b0, start: 1'b0, prev: 1'b1};
        end
        state_d = S_F_CLR;
      end
      S_F_CLR: begin
        addr_o = idx_q[IW-1:0];
        we_o   = '{len: 1'b1, used: 1'b1, start: 1'b0, prev: 1'b0};
        if ((idx_q != '0) && (prev_q < GC_L)) begin
          state_d = S_F_LRD;
        end else begin
          done_d   = 1'b1;
          status_d = STAT_OK;
          off_d    = '0;
          state_d  = S_IDLE;
        end
      end
      S_F_LRD: begin
        addr_o  = prev_q[IW-1:0];
        state_d = S_F_LCHK;
      end
      S_F_LCHK: begin
        // Merge into a free left neighbor.
        alu_a_o = r_len_i;
        alu_b_o = len_q;
        if (!r_used_i) begin
          len_d   = alu_y_i[LW-1:0];
          addr_o  = prev_q[IW-1:0];
          we_o    = '{len: 1'b1, used: 1'b0, start: 1'b0, prev: 1'b0};
          w_len_o = alu_y_i[LW-1:0];
          state_d = S_F_LST;
        end else begin
          done_d   = 1'b1;
          status_d = STAT_OK;
          off_d    = '0;
          state_d  = S_IDLE;
        end
      end
      S_F_LST: begin
        addr_o  = idx_q[IW-1:0];
        we_o    = '{len: 1'b0, used: 1'b0, start: 1'b1, prev: 1'b0};
        state_d = S_F_LLNK;
      end
      S_F_LLNK: begin
        alu_a_o  = prev_q;
        addr_o   = alu_y_i[IW-1:0];
        w_prev_o = prev_q;
        if (alu_y_i < GC_Y) begin
          we_o = '{len: 1'b0, used: 1'b0, start: 1'b0, prev: 1'b1};
        end
        done_d   = 1'b1;
        status_d = STAT_OK;
        off_d    = '0;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      status_q <= STAT_OK;
      off_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      done_q   <= done_d;
      status_q <= status_d;
      off_q    <= off_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    want_q <= want_d;
    len_q  <= len_d;
    prev_q <= prev_d;
    rest_q <= rest_d;
    diff_q <= diff_d;
    tmp_q  <= tmp_d;
    idx_q  <= idx_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign chunk_offset_o = off_q;

  // No result may appear while the table is being cleared.
  a_no_done_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !done_q) else $error("result during clearing pass");

  // A failed result carries a zero offset; a free also always returns a zero offset.
  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q != STAT_OK)) |-> (off_q == '0)) else $error("offset not zero");

  // A split always leaves a nonempty remainder.
  a_split_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_SPLIT2) |-> (diff_q != '0)) else $error("empty split remainder");

  // The search pointer stays inside the page.
  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_A_RD) |-> (i_q < GC_L)) else $error("search beyond page");

endmodule

// ----- rtl/core/first_fit_page_allocator_top.sv -----
// First-fit page allocator. After reset the chunk table is cleared one entry
// per cycle, with busy high. A refused size or a free offset that is
// unaligned or past the page is answered in the cycle after start. An
// allocate reads and checks each chunk of the first-fit walk, then splits any
// remainder off as a new free chunk and marks the chunk used; a free merges
// with free right and left neighbors. The walk is bounded by the single chunk
// table port and the one shared adder. Each result is shown for exactly one
// cycle on done_o and cannot be held off; it must be taken when it appears.
// GRANULE_BYTES must be a power of two and PAGE_BYTES must equal
// GRANULE_BYTES*GRANULE_COUNT.
module first_fit_page_allocator_top import ffpa_pkg::*; #(
  parameter int PAGE_BYTES    = PageBytesDef,
  parameter int GRANULE_BYTES = GranuleBytesDef,
  parameter int GRANULE_COUNT = GranuleCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [12:0] request_bytes_i,
  input  logic [11:0] free_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [11:0] chunk_offset_o
);

  localparam int IW = $clog2(GRANULE_COUNT);
  localparam int LW = $clog2(GRANULE_COUNT + 1);

  logic [IW-1:0] addr;
  mem_we_t       we;
  logic [LW-1:0] w_len, w_prev, r_len, r_prev, alu_a, alu_b;
  logic          w_used, w_start, r_used, r_start, alu_sub;
  logic [LW:0]   alu_y;

  // Sequencer.
  ffpa_ctrl #(
    .PAGE_BYTES(PAGE_BYTES), .GRANULE_BYTES(GRANULE_BYTES), .GRANULE_COUNT(GRANULE_COUNT)
  ) u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .action_i, .request_bytes_i, .free_offset_i,
    .done_o, .status_o, .chunk_offset_o,
    .addr_o(addr), .we_o(we), .w_len_o(w_len), .w_used_o(w_used),
    .w_start_o(w_start), .w_prev_o(w_prev),
    .r_len_i(r_len), .r_used_i(r_used), .r_start_i(r_start), .r_prev_i(r_prev),
    .alu_a_o(alu_a), .alu_b_o(alu_b), .alu_sub_o(alu_sub), .alu_y_i(alu_y)
  );

  // Shared adder.
  ffpa_alu #(.W(LW)) u_alu (
    .a_i(alu_a), .b_i(alu_b), .sub_i(alu_sub), .y_o(alu_y)
  );

  // Chunk table.
  ffpa_mem #(.GRANULE_COUNT(GRANULE_COUNT)) u_mem (
    .clk_i, .addr_i(addr), .we_i(we), .w_len_i(w_len), .w_used_i(w_used),
    .w_start_i(w_start), .w_prev_i(w_prev), .r_len_o(r_len), .r_used_o(r_used),
    .r_start_o(r_start), .r_prev_o(r_prev)
  );

endmodule
